### rtl/core/wav_to_packed_sample_memory_top_assert.svh
// Assertion macros for the block; only the datapath module includes them.
`ifndef WAV_TO_PACKED_SAMPLE_MEMORY_TOP_ASSERT_SVH
`define WAV_TO_PACKED_SAMPLE_MEMORY_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define WTPSM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WTPSM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/wtpsm_pkg.sv
package wtpsm_pkg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_RIFF,
        PH_CHUNK_ID,
        PH_CHUNK_SIZE,
        PH_CHUNK_SKIP,
        PH_FMT_SIZE,
        PH_FMT_BODY,
        PH_FMT_EXTRA,
        PH_DATA_ID,
        PH_JUNK_SIZE,
        PH_JUNK_SKIP,
        PH_DATA_SIZE,
        PH_SAMPLES,
        PH_PAD,
        PH_DONE
    } phase_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RIFF,
        OP_FIELD,
        OP_SKIP_LOAD,
        OP_SKIP_DEC,
        OP_FMT_SIZE,
        OP_FMT_BODY,
        OP_DATA_SIZE,
        OP_SAMPLE,
        OP_PAD
    } op_t;

    // Result status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_COMPRESSED   = 3'd1;
    localparam logic [2:0] ST_BAD_RATE     = 3'd2;
    localparam logic [2:0] ST_BAD_CHANNELS = 3'd3;
    localparam logic [2:0] ST_BAD_BITS     = 3'd4;
    localparam logic [2:0] ST_TOO_LONG     = 3'd5;
    localparam logic [2:0] ST_MISALIGNED   = 3'd6;

    localparam logic [31:0] ID_FMT      = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA     = 32'h6174_6164;
    localparam logic [31:0] RATE_44100  = 32'd44100;
    localparam logic [31:0] RATE_22050  = 32'd22050;
    localparam logic [31:0] RATE_11025  = 32'd11025;
    localparam logic [31:0] RIFF_HDR_M1 = 32'd11;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [23:0] word_index;
        logic        last;
        logic [2:0]  status;
    } out_item_t;

    typedef struct packed {
        op_t  op;
        logic step;
        logic restart;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic field_done;
        logic id_fmt;
        logic id_data;
        logic val_zero;
        logic riff_end;
        logic skip_end;
        logic fmt_fail;
        logic fmt_extra;
        logic size_stop;
        logic stream_end;
        logic pad_more;
        logic pad_final;
    } dp_status_t;

    // u-law style encode of one 16-bit sample (sign, segment, mantissa)
    function automatic logic [7:0] ulaw_encode(input logic [15:0] s);
        logic [16:0] mag;
        logic [14:0] m;
        logic        sgn;
        logic [7:0]  res;
        sgn = s[15];
        mag = sgn ? (17'd0 - {s[15], s}) : {1'b0, s};
        mag = mag + 17'd128;
        m   = (mag > 17'h07FFF) ? 15'h7FFF : mag[14:0];
        if (m[14])      res = {sgn, 3'd7, m[13:10]};
        else if (m[13]) res = {sgn, 3'd6, m[12:9]};
        else if (m[12]) res = {sgn, 3'd5, m[11:8]};
        else if (m[11]) res = {sgn, 3'd4, m[10:7]};
        else if (m[10]) res = {sgn, 3'd3, m[9:6]};
        else if (m[9])  res = {sgn, 3'd2, m[8:5]};
        else if (m[8])  res = {sgn, 3'd1, m[7:4]};
        else            res = {sgn, 3'd0, m[6:3]};
        return res;
    endfunction

endpackage

### rtl/core/wtpsm_ctrl.sv
module wtpsm_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   file_start,
    output logic                   in_ready,
    input  wtpsm_pkg::dp_status_t  st,
    output wtpsm_pkg::dp_cmd_t     cmd
);

    wtpsm_pkg::phase_t state_reg;
    wtpsm_pkg::phase_t state_next;
    wtpsm_pkg::phase_t eff_state;
    logic              fire;
    logic              in_pad;

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wtpsm_pkg::PH_RIFF;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Handshake and command outputs
    always_comb
    begin
        in_pad      = (state_reg == wtpsm_pkg::PH_PAD);
        in_ready    = st.out_free && !in_pad;
        fire        = in_valid && in_ready;
        cmd.restart = fire && file_start;
        eff_state   = cmd.restart ? wtpsm_pkg::PH_RIFF : state_reg;
        cmd.step    = fire || (in_pad && st.out_free);
        case (eff_state)
            wtpsm_pkg::PH_RIFF:       cmd.op = wtpsm_pkg::OP_RIFF;
            wtpsm_pkg::PH_CHUNK_ID:   cmd.op = wtpsm_pkg::OP_FIELD;
            wtpsm_pkg::PH_DATA_ID:    cmd.op = wtpsm_pkg::OP_FIELD;
            wtpsm_pkg::PH_CHUNK_SIZE: cmd.op = wtpsm_pkg::OP_SKIP_LOAD;
            wtpsm_pkg::PH_JUNK_SIZE:  cmd.op = wtpsm_pkg::OP_SKIP_LOAD;
            wtpsm_pkg::PH_CHUNK_SKIP: cmd.op = wtpsm_pkg::OP_SKIP_DEC;
            wtpsm_pkg::PH_FMT_EXTRA:  cmd.op = wtpsm_pkg::OP_SKIP_DEC;
            wtpsm_pkg::PH_JUNK_SKIP:  cmd.op = wtpsm_pkg::OP_SKIP_DEC;
            wtpsm_pkg::PH_FMT_SIZE:   cmd.op = wtpsm_pkg::OP_FMT_SIZE;
            wtpsm_pkg::PH_FMT_BODY:   cmd.op = wtpsm_pkg::OP_FMT_BODY;
            wtpsm_pkg::PH_DATA_SIZE:  cmd.op = wtpsm_pkg::OP_DATA_SIZE;
            wtpsm_pkg::PH_SAMPLES:    cmd.op = wtpsm_pkg::OP_SAMPLE;
            wtpsm_pkg::PH_PAD:        cmd.op = wtpsm_pkg::OP_PAD;
            default:                  cmd.op = wtpsm_pkg::OP_NONE;
        endcase
    end

    // Next phase
    always_comb
    begin
        state_next = state_reg;
        if (cmd.step)
        begin
            state_next = eff_state;
            case (eff_state)
                wtpsm_pkg::PH_RIFF:
                    if (st.riff_end) state_next = wtpsm_pkg::PH_CHUNK_ID;
                wtpsm_pkg::PH_CHUNK_ID:
                    if (st.field_done)
                        state_next = st.id_fmt ? wtpsm_pkg::PH_FMT_SIZE
                                               : wtpsm_pkg::PH_CHUNK_SIZE;
                wtpsm_pkg::PH_CHUNK_SIZE:
                    if (st.field_done)
                        state_next = st.val_zero ? wtpsm_pkg::PH_CHUNK_ID
                                                 : wtpsm_pkg::PH_CHUNK_SKIP;
                wtpsm_pkg::PH_JUNK_SIZE:
                    if (st.field_done)
                        state_next = st.val_zero ? wtpsm_pkg::PH_DATA_ID
                                                 : wtpsm_pkg::PH_JUNK_SKIP;
                wtpsm_pkg::PH_CHUNK_SKIP:
                    if (st.skip_end) state_next = wtpsm_pkg::PH_CHUNK_ID;
                wtpsm_pkg::PH_FMT_EXTRA:
                    if (st.skip_end) state_next = wtpsm_pkg::PH_DATA_ID;
                wtpsm_pkg::PH_JUNK_SKIP:
                    if (st.skip_end) state_next = wtpsm_pkg::PH_DATA_ID;
                wtpsm_pkg::PH_FMT_SIZE:
                    if (st.field_done) state_next = wtpsm_pkg::PH_FMT_BODY;
                wtpsm_pkg::PH_FMT_BODY:
                    if (st.fmt_fail)       state_next = wtpsm_pkg::PH_DONE;
                    else if (st.fmt_extra) state_next = wtpsm_pkg::PH_FMT_EXTRA;
                    else if (st.pad_final) state_next = wtpsm_pkg::PH_DATA_ID;
                wtpsm_pkg::PH_DATA_ID:
                    if (st.field_done)
                        state_next = st.id_data ? wtpsm_pkg::PH_DATA_SIZE
                                                : wtpsm_pkg::PH_JUNK_SIZE;
                wtpsm_pkg::PH_DATA_SIZE:
                    if (st.field_done)
                        state_next = st.size_stop ? wtpsm_pkg::PH_DONE
                                                  : wtpsm_pkg::PH_SAMPLES;
                wtpsm_pkg::PH_SAMPLES:
                    if (st.stream_end)
                        state_next = st.pad_more ? wtpsm_pkg::PH_PAD
                                                 : wtpsm_pkg::PH_DONE;
                wtpsm_pkg::PH_PAD:
                    if (st.pad_final) state_next = wtpsm_pkg::PH_DONE;
                default:
                    state_next = eff_state;
            endcase
        end
    end

endmodule

### rtl/core/wtpsm_dp.sv
module wtpsm_dp
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pcm_mode,
    input  wtpsm_pkg::in_item_t    in_data,
    input  wtpsm_pkg::dp_cmd_t     cmd,
    output wtpsm_pkg::dp_status_t  st,
    output logic                   out_valid,
    input  logic                   out_ready,
    output wtpsm_pkg::out_item_t   out_data
);

    logic [1:0]  fbc_reg, fbc_next;
    logic [31:0] fshift_reg, fshift_next;
    logic [31:0] skip_reg, skip_next;
    logic        stereo_reg, stereo_next;
    logic [1:0]  rate_reg, rate_next;
    logic [23:0] left_cnt_reg, left_cnt_next;
    logic [6:0]  pad_reg, pad_next;
    logic [15:0] lsamp_reg, lsamp_next;
    logic [31:0] buf_reg, buf_next;
    logic [1:0]  pc_reg, pc_next;
    logic [23:0] wc_reg, wc_next;
    logic [3:0]  fpos_reg, fpos_next;
    logic [2:0]  ferr_reg, ferr_next;
    logic        mis_reg, mis_next;
    logic        pcm_lat_reg, pcm_lat_next;
    logic [6:0]  pw_reg, pw_next;
    logic        out_valid_reg;
    wtpsm_pkg::out_item_t out_reg;

    wtpsm_pkg::out_item_t emit_item;
    logic        emit_req;
    logic        out_free;
    logic [7:0]  b;
    logic [31:0] fv;
    logic        fdone;
    logic        take;
    logic [2:0]  err_v;
    logic [30:0] cnt;
    logic [8:0]  blk, rem, pad9;
    logic [15:0] fs16, audio;
    logic [16:0] sum, adj;
    logic        sdone;
    logic [2:0]  cnt3;
    logic [31:0] wbuf;
    logic [7:0]  ubyte, padbytes;
    logic [8:0]  total;
    logic [23:0] sl;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign b         = in_data.in_byte;

    // Parse, pack and emit for one step
    always_comb
    begin
        fbc_next = fbc_reg; fshift_next = fshift_reg; skip_next = skip_reg;
        stereo_next = stereo_reg; rate_next = rate_reg; left_cnt_next = left_cnt_reg;
        pad_next = pad_reg; lsamp_next = lsamp_reg; buf_next = buf_reg;
        pc_next = pc_reg; wc_next = wc_reg; fpos_next = fpos_reg;
        ferr_next = ferr_reg; mis_next = mis_reg; pcm_lat_next = pcm_lat_reg;
        pw_next = pw_reg;
        emit_req = 1'b0; emit_item = '0;
        st = '0; st.out_free = out_free;
        err_v = wtpsm_pkg::ST_OK; cnt = '0; blk = '0; rem = '0; pad9 = '0;
        fs16 = '0; audio = '0; sum = '0; adj = '0; sdone = 1'b0; cnt3 = '0;
        wbuf = '0; ubyte = '0; padbytes = '0; total = '0; sl = '0;

        // restart clears file state before this byte is applied
        if (cmd.step && cmd.restart)
        begin
            fbc_next = '0; fshift_next = '0; skip_next = '0; stereo_next = 1'b0;
            rate_next = '0; left_cnt_next = '0; pad_next = '0; lsamp_next = '0;
            buf_next = '0; pc_next = '0; wc_next = '0; fpos_next = '0;
            ferr_next = wtpsm_pkg::ST_OK; mis_next = 1'b0; pcm_lat_next = 1'b1;
            pw_next = '0;
        end

        // assemble the little-endian field
        case (fbc_next)
            2'd0:    fv = fshift_next | {24'd0, b};
            2'd1:    fv = fshift_next | {16'd0, b, 8'd0};
            2'd2:    fv = fshift_next | {8'd0, b, 16'd0};
            default: fv = fshift_next | {b, 24'd0};
        endcase
        fdone         = (fbc_next == 2'd3);
        st.field_done = fdone;
        st.id_fmt     = (fv == wtpsm_pkg::ID_FMT);
        st.id_data    = (fv == wtpsm_pkg::ID_DATA);
        st.val_zero   = (fv == 32'd0);
        take = (cmd.op == wtpsm_pkg::OP_FIELD) || (cmd.op == wtpsm_pkg::OP_SKIP_LOAD) ||
               (cmd.op == wtpsm_pkg::OP_FMT_SIZE) || (cmd.op == wtpsm_pkg::OP_FMT_BODY) ||
               (cmd.op == wtpsm_pkg::OP_DATA_SIZE);

        if (cmd.step)
        begin
            if (take)
            begin
                if (fdone)
                begin
                    fshift_next = '0;
                    fbc_next    = '0;
                end
                else
                begin
                    fshift_next = fv;
                    fbc_next    = fbc_next + 2'd1;
                end
            end

            case (cmd.op)
                wtpsm_pkg::OP_RIFF:
                begin
                    if (skip_next >= wtpsm_pkg::RIFF_HDR_M1)
                    begin
                        skip_next   = '0;
                        st.riff_end = 1'b1;
                    end
                    else
                    begin
                        skip_next = skip_next + 32'd1;
                    end
                end
                wtpsm_pkg::OP_SKIP_LOAD:
                begin
                    if (fdone) skip_next = fv;
                end
                wtpsm_pkg::OP_SKIP_DEC:
                begin
                    st.skip_end = (skip_next == 32'd1);
                    skip_next   = skip_next - 32'd1;
                end
                wtpsm_pkg::OP_FMT_SIZE:
                begin
                    if (fdone)
                    begin
                        skip_next = (fv > wtpsm_pkg::FMT_BODY_LEN)
                                    ? fv - wtpsm_pkg::FMT_BODY_LEN : 32'd0;
                        fpos_next = '0;
                        ferr_next = wtpsm_pkg::ST_OK;
                    end
                end
                wtpsm_pkg::OP_FMT_BODY:
                begin
                    if (fdone)
                    begin
                        case (fpos_next)
                            4'd3:
                            begin
                                if (fv[15:0] != 16'd1)
                                    ferr_next = wtpsm_pkg::ST_COMPRESSED;
                                else if (fv[31:16] != 16'd1 && fv[31:16] != 16'd2)
                                    ferr_next = wtpsm_pkg::ST_BAD_CHANNELS;
                                stereo_next = (fv[31:16] == 16'd2);
                            end
                            4'd7:
                            begin
                                if (fv == wtpsm_pkg::RATE_44100)      rate_next = 2'd1;
                                else if (fv == wtpsm_pkg::RATE_22050) rate_next = 2'd2;
                                else if (fv == wtpsm_pkg::RATE_11025) rate_next = 2'd3;
                                else
                                begin
                                    rate_next = 2'd0;
                                    if (ferr_next != wtpsm_pkg::ST_COMPRESSED)
                                        ferr_next = wtpsm_pkg::ST_BAD_RATE;
                                end
                            end
                            4'd15:
                            begin
                                err_v = ferr_next;
                                if (err_v == wtpsm_pkg::ST_OK && fv[31:16] != 16'd16)
                                    err_v = wtpsm_pkg::ST_BAD_BITS;
                                ferr_next    = err_v;
                                st.fmt_fail  = (err_v != wtpsm_pkg::ST_OK);
                                st.fmt_extra = (skip_next != 32'd0);
                                st.pad_final = 1'b1;
                                if (err_v != wtpsm_pkg::ST_OK)
                                begin
                                    emit_req         = 1'b1;
                                    emit_item.last   = 1'b1;
                                    emit_item.status = err_v;
                                end
                            end
                            default:
                            begin
                                ferr_next = ferr_next;
                            end
                        endcase
                    end
                    fpos_next = fpos_next + 4'd1;
                end
                wtpsm_pkg::OP_DATA_SIZE:
                begin
                    if (fdone)
                    begin
                        if (stereo_next)
                        begin
                            mis_next = (fv[1:0] != 2'd0);
                            cnt      = {1'b0, fv[31:2]};
                        end
                        else
                        begin
                            mis_next = fv[0];
                            cnt      = fv[31:1];
                        end
                        if (cnt[30:24] != 7'd0)
                        begin
                            st.size_stop     = 1'b1;
                            emit_req         = 1'b1;
                            emit_item.last   = 1'b1;
                            emit_item.status = wtpsm_pkg::ST_TOO_LONG;
                        end
                        else
                        begin
                            st.size_stop  = (cnt == 31'd0);
                            blk           = 9'd256 >> rate_next;
                            rem           = cnt[8:0] & (blk - 9'd1);
                            pad9          = (rem != 9'd0) ? blk - rem : 9'd0;
                            pad_next      = pad9[6:0];
                            left_cnt_next = cnt[23:0];
                            pcm_lat_next  = pcm_mode;
                            buf_next      = '0;
                            pc_next       = '0;
                            emit_req      = 1'b1;
                            emit_item.out_word   = {pcm_mode, 5'd0, rate_next, cnt[23:0]};
                            emit_item.word_index = wc_next;
                            emit_item.last       = (cnt == 31'd0);
                            emit_item.status     = mis_next ? wtpsm_pkg::ST_MISALIGNED
                                                            : wtpsm_pkg::ST_OK;
                            wc_next = wc_next + 24'd1;
                        end
                    end
                end
                wtpsm_pkg::OP_SAMPLE:
                begin
                    fs16 = fshift_next[15:0] | (fbc_next[0] ? {b, 8'd0} : {8'd0, b});
                    fshift_next = {16'd0, fs16};
                    if (fbc_next[0])
                    begin
                        fshift_next = '0;
                        if (!stereo_next)
                        begin
                            audio = fs16;
                            sdone = 1'b1;
                        end
                        else if (fbc_next == 2'd1)
                        begin
                            lsamp_next = fs16;
                        end
                        else
                        begin
                            sum   = {lsamp_next[15], lsamp_next} + {fs16[15], fs16};
                            adj   = sum + {16'd0, sum[16] & sum[0]};
                            audio = adj[16:1];
                            sdone = 1'b1;
                        end
                    end
                    fbc_next = stereo_next ? fbc_next + 2'd1 : {1'b0, ~fbc_next[0]};
                    if (sdone)
                    begin
                        fbc_next = '0;
                        wbuf     = buf_next;
                        if (pcm_lat_next)
                        begin
                            if (pc_next[1]) wbuf[31:16] = audio;
                            else            wbuf[15:0]  = audio;
                            cnt3 = {1'b0, pc_next} + 3'd2;
                        end
                        else
                        begin
                            ubyte = wtpsm_pkg::ulaw_encode(audio);
                            case (pc_next)
                                2'd0:    wbuf[7:0]   = ubyte;
                                2'd1:    wbuf[15:8]  = ubyte;
                                2'd2:    wbuf[23:16] = ubyte;
                                default: wbuf[31:24] = ubyte;
                            endcase
                            cnt3 = {1'b0, pc_next} + 3'd1;
                        end
                        sl = left_cnt_next - 24'd1;
                        left_cnt_next = sl;
                        padbytes = pcm_lat_next ? {pad_next, 1'b0} : {1'b0, pad_next};
                        total = {7'd0, cnt3[1:0]} + {1'b0, padbytes} + 9'd3;
                        if (cnt3[2])
                        begin
                            emit_req             = 1'b1;
                            emit_item.out_word   = wbuf;
                            emit_item.word_index = wc_next;
                            emit_item.status     = mis_next ? wtpsm_pkg::ST_MISALIGNED
                                                            : wtpsm_pkg::ST_OK;
                            wc_next  = wc_next + 24'd1;
                            buf_next = '0;
                            pc_next  = '0;
                        end
                        else
                        begin
                            buf_next = wbuf;
                            pc_next  = cnt3[1:0];
                        end
                        if (sl == 24'd0)
                        begin
                            st.stream_end  = 1'b1;
                            pw_next        = total[8:2];
                            st.pad_more    = (total[8:2] != 7'd0);
                            emit_item.last = (total[8:2] == 7'd0);
                        end
                    end
                end
                wtpsm_pkg::OP_PAD:
                begin
                    emit_req             = 1'b1;
                    emit_item.out_word   = buf_next;
                    emit_item.word_index = wc_next;
                    emit_item.status     = mis_next ? wtpsm_pkg::ST_MISALIGNED
                                                    : wtpsm_pkg::ST_OK;
                    emit_item.last       = (pw_next == 7'd1);
                    st.pad_final         = (pw_next == 7'd1);
                    wc_next  = wc_next + 24'd1;
                    buf_next = '0;
                    pc_next  = '0;
                    pw_next  = pw_next - 7'd1;
                end
                default:
                begin
                    emit_req = 1'b0;
                end
            endcase
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fbc_reg <= '0; fshift_reg <= '0; skip_reg <= '0; stereo_reg <= 1'b0;
            rate_reg <= '0; left_cnt_reg <= '0; pad_reg <= '0; lsamp_reg <= '0;
            buf_reg <= '0; pc_reg <= '0; wc_reg <= '0; fpos_reg <= '0;
            ferr_reg <= '0; mis_reg <= 1'b0; pcm_lat_reg <= 1'b1; pw_reg <= '0;
        end
        else
        begin
            fbc_reg <= fbc_next; fshift_reg <= fshift_next; skip_reg <= skip_next;
            stereo_reg <= stereo_next; rate_reg <= rate_next;
            left_cnt_reg <= left_cnt_next; pad_reg <= pad_next;
            lsamp_reg <= lsamp_next; buf_reg <= buf_next; pc_reg <= pc_next;
            wc_reg <= wc_next; fpos_reg <= fpos_next; ferr_reg <= ferr_next;
            mis_reg <= mis_next; pcm_lat_reg <= pcm_lat_next; pw_reg <= pw_next;
        end
    end

    // Output register: load on emit, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_req)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_req)
        begin
            out_reg <= emit_item;
        end
    end

`include "wav_to_packed_sample_memory_top_assert.svh"

    `WTPSM_ASSERT_NOW(a_pcm_pairs, pcm_lat_reg, !pc_reg[0], "PCM packing lost pair alignment")
    `WTPSM_ASSERT_NOW(a_emit_free, emit_req, out_free, "word emitted into a full output slot")
    `WTPSM_ASSERT_NOW(a_err_last, out_valid_reg && out_reg.status != wtpsm_pkg::ST_OK && out_reg.status != wtpsm_pkg::ST_MISALIGNED, out_reg.last && out_reg.word_index == 24'd0, "error result not final")
    `WTPSM_ASSERT_NEXT(a_pad_drain, cmd.step && cmd.op == wtpsm_pkg::OP_PAD, out_valid_reg, "pad step produced no word")

endmodule

### rtl/core/wav_to_packed_sample_memory_top.sv
// WAV byte stream to packed sample memory words.
// Input channel: in_valid/in_ready with in_data (in_byte, file_start). Set
// file_start on the first byte of each file to restart the parser.
// Output channel: out_valid/out_ready with out_data (out_word, word_index,
// last, status). A header word comes first, then packed PCM or u-law words,
// zero-padded to the block length of the rate; last marks the final word.
// A format error gives one word with last set and the error status.
// Configuration: cfg_valid/cfg_ready/cfg_data writes pcm_mode (always ready);
// the mode is sampled when the data chunk header is parsed.
// Throughput: one byte per cycle while in_ready is high; a word appears in
// the output register in the cycle after the byte that completes it.
// After the final sample the input stalls while the padding words (up to 64)
// are drained through the single output register.
// A stalled receiver holds the output register; the input then stalls too,
// since each transfer into the register needs the slot free.
// Reset: parser waits for a RIFF header, pcm_mode returns to 1, output empty.
module wav_to_packed_sample_memory_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wtpsm_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output wtpsm_pkg::out_item_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);

    logic                  pcm_mode_reg;
    wtpsm_pkg::dp_cmd_t    cmd;
    wtpsm_pkg::dp_status_t st;

    assign cfg_ready = 1'b1;

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcm_mode_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            pcm_mode_reg <= cfg_data;
        end
    end

    wtpsm_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .file_start (in_data.file_start),
        .in_ready   (in_ready),
        .st         (st),
        .cmd        (cmd)
    );

    wtpsm_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pcm_mode  (pcm_mode_reg),
        .in_data   (in_data),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
